[hdl/cde_pkg.sv]
// Shared types and constants for the circular deque engine.
// No dependencies; imported by cde_index_unit and circular_deque_engine.
`default_nettype none

package cde_pkg;

    localparam int RING_DEPTH = 128;
    localparam int IDX_BITS   = $clog2(RING_DEPTH);
    localparam int ITEM_BITS  = 32;

    // Field widths fixed by the stream format
    localparam int REQ_BITS   = 3;
    localparam int VALUE_BITS = 32;
    localparam int STAT_BITS  = 2;
    localparam int CNT_BITS   = 7;
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 48;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_REAR  = 3'd5
    } req_type_t;

    localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;

    // Store access and result summary for one request
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [IDX_BITS-1:0]  addr;
        logic [STAT_BITS-1:0] status;
        logic [CNT_BITS-1:0]  count;
    } cde_op_t;

endpackage

`default_nettype wire

[hdl/cde_index_unit.sv]
// Front/rear index registers and per-request decode for the deque.
// Depends on cde_pkg.
`default_nettype none

module cde_index_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          req_accept,
    input  wire logic [cde_pkg::REQ_BITS-1:0]  req_type,
    output cde_pkg::cde_op_t                   op
);
    import cde_pkg::*;

    logic [IDX_BITS-1:0] front_reg, front_next;
    logic [IDX_BITS-1:0] rear_reg,  rear_next;
    logic [IDX_BITS-1:0] cur_count;
    logic                empty, full;

    assign empty     = (front_reg == rear_reg);
    assign full      = (front_reg == IDX_BITS'(rear_reg + 1'b1));
    assign cur_count = IDX_BITS'(rear_reg - front_reg);

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        op.addr    = front_reg;
        op.status  = ST_DONE;
        unique case (req_type)
            REQ_PUSH_FRONT: begin
                if (full) begin
                    op.status = ST_FULL;
                end else begin
                    front_next = IDX_BITS'(front_reg - 1'b1);
                    op.addr    = front_next;
                    op.wr_en   = 1'b1;
                end
            end
            REQ_PUSH_REAR: begin
                if (full) begin
                    op.status = ST_FULL;
                end else begin
                    op.addr   = rear_reg;
                    op.wr_en  = 1'b1;
                    rear_next = IDX_BITS'(rear_reg + 1'b1);
                end
            end
            REQ_POP_FRONT: begin
                if (empty) op.status = ST_EMPTY;
                else       front_next = IDX_BITS'(front_reg + 1'b1);
            end
            REQ_POP_REAR: begin
                if (empty) op.status = ST_EMPTY;
                else       rear_next = IDX_BITS'(rear_reg - 1'b1);
            end
            REQ_PEEK_FRONT: begin
                if (empty) begin
                    op.status = ST_EMPTY;
                end else begin
                    op.addr  = front_reg;
                    op.rd_en = 1'b1;
                end
            end
            REQ_PEEK_REAR: begin
                if (empty) begin
                    op.status = ST_EMPTY;
                end else begin
                    op.addr  = IDX_BITS'(rear_reg - 1'b1);
                    op.rd_en = 1'b1;
                end
            end
            default: begin
                // unused codes: no change, done
            end
        endcase
        op.count = CNT_BITS'(IDX_BITS'(rear_next - front_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            rear_reg  <= '0;
        end else if (req_accept) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_accept && op.wr_en) |=> cur_count == IDX_BITS'($past(cur_count) + 1'b1))
        else $error("successful push did not add one item");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_accept && op.status == ST_DONE
         && (req_type == REQ_POP_FRONT || req_type == REQ_POP_REAR))
        |=> cur_count == IDX_BITS'($past(cur_count) - 1'b1))
        else $error("successful pop did not remove one item");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !req_accept |=> $stable(front_reg) && $stable(rear_reg))
        else $error("indices moved without a request");

    a_reject_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.status != ST_DONE) |-> !op.wr_en && !op.rd_en)
        else $error("rejected request touched the store");

endmodule

`default_nettype wire

[hdl/circular_deque_engine.sv]
// Circular deque engine top level: stream ports, item store, result register.
// Depends on cde_pkg and cde_index_unit.
//
// Usage:
//   Requests enter on the s_axis channel, one per accepted beat: a request
//   code (push/pop/peek at front or rear) and, for pushes, the value.
//   Each request gives exactly one result on the m_axis channel: the peeked
//   value (zero unless a successful peek), a status (done, full, empty) and
//   the number of items held after the request.
//   A result is valid in the cycle after request accept. Throughput is one
//   request per cycle while the receiver keeps up: indices update at accept,
//   and the single store port does either the push write or the peek read
//   in that same cycle, with the read data captured into the result register.
//   When the receiver stalls, the result register holds and s_axis_tready
//   drops until the result is taken; s_axis_tready follows m_axis_tready
//   while a result is pending.
//   Reset (synchronous, aresetn low) empties the queue and drops any pending
//   result. The store itself is not cleared; entries are only read after
//   they have been pushed.
`default_nettype none

module circular_deque_engine (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // [2:0] req_type, [34:3] push_value, [39:35] zero
    input  wire logic [cde_pkg::S_DATA_BITS-1:0] s_axis_tdata,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [31:0] read_value, [33:32] status, [40:34] fill_count, [47:41] zero
    output      logic [cde_pkg::M_DATA_BITS-1:0] m_axis_tdata
);
    import cde_pkg::*;

    logic                    req_accept;
    logic [REQ_BITS-1:0]     req_type;
    logic [VALUE_BITS-1:0]   push_value;
    cde_op_t                 op;

    logic [ITEM_BITS-1:0]    item_store [RING_DEPTH];
    logic [ITEM_BITS-1:0]    rd_data_reg;

    logic                    res_valid_reg;
    logic                    res_peek_reg;
    logic [STAT_BITS-1:0]    res_status_reg;
    logic [CNT_BITS-1:0]     res_count_reg;
    logic [VALUE_BITS-1:0]   read_value;

    assign req_type   = s_axis_tdata[REQ_BITS-1:0];
    assign push_value = s_axis_tdata[REQ_BITS +: VALUE_BITS];

    assign s_axis_tready = !res_valid_reg || m_axis_tready;
    assign req_accept    = s_axis_tvalid && s_axis_tready;

    cde_index_unit u_index (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (req_accept),
        .req_type   (req_type),
        .op         (op)
    );

    // Single-port store: a request either writes or reads, never both
    always_ff @(posedge aclk) begin
        if (req_accept && op.wr_en) begin
            item_store[op.addr] <= ITEM_BITS'(push_value);
        end
        if (req_accept && op.rd_en) begin
            rd_data_reg <= item_store[op.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (req_accept) begin
            res_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_accept) begin
            res_peek_reg   <= op.rd_en;
            res_status_reg <= op.status;
            res_count_reg  <= op.count;
        end
    end

    assign read_value    = res_peek_reg ? VALUE_BITS'(rd_data_reg) : '0;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = M_DATA_BITS'({res_count_reg, res_status_reg, read_value});

    a_peek_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && res_peek_reg) |-> res_status_reg == ST_DONE)
        else $error("peek data presented with a reject status");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        req_accept |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(res_count_reg)
                                              && $stable(res_status_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for circular_deque_engine: stream requests in, results out.
// Depends on cde_pkg and the circular_deque_engine RTL; predicts every result in-line.
`default_nettype none

module tb_top;
    import cde_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic [STAT_BITS-1:0]  status;
        logic [CNT_BITS-1:0]   fill_count;
    } deque_result_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [2:0] req_type, [34:3] push_value, [39:35] zero
    logic [S_DATA_BITS-1:0] s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] read_value, [33:32] status, [40:34] fill_count, [47:41] zero
    logic [M_DATA_BITS-1:0] m_axis_tdata;

    // Predictor state: ring contents and the two end indices
    logic [ITEM_BITS-1:0] ring_mem [RING_DEPTH];
    logic [IDX_BITS-1:0]  ring_front = '0;
    logic [IDX_BITS-1:0]  ring_rear  = '0;

    deque_result_t pending_results [$];
    int            error_count   = 0;
    int            requests_sent = 0;
    int            send_idle_pct = 27;
    int            recv_idle_pct = 66;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_BITS-1:0] REQ_UNUSED_7 = 3'd7;

    circular_deque_engine i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [IDX_BITS-1:0] held_items();
        logic [IDX_BITS-1:0] n;
        n = ring_rear - ring_front;
        return n;
    endfunction

    // Applies one request to the predictor state and returns the expected result
    function automatic deque_result_t deque_predict(input logic [REQ_BITS-1:0] code,
                                                    input logic [VALUE_BITS-1:0] value);
        deque_result_t       r;
        logic [IDX_BITS-1:0] next_rear;
        logic [IDX_BITS-1:0] prev_rear;
        logic                is_empty;
        logic                is_full;
        r         = '0;
        next_rear = ring_rear + 1'b1;
        prev_rear = ring_rear - 1'b1;
        is_empty  = (ring_front == ring_rear);
        is_full   = (ring_front == next_rear);
        r.status  = ST_DONE;
        case (code)
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    r.status = ST_FULL;
                end else begin
                    ring_front           = ring_front - 1'b1;
                    ring_mem[ring_front] = value;
                end
            end
            REQ_PUSH_REAR: begin
                if (is_full) begin
                    r.status = ST_FULL;
                end else begin
                    ring_mem[ring_rear] = value;
                    ring_rear           = next_rear;
                end
            end
            REQ_POP_FRONT: begin
                if (is_empty) r.status = ST_EMPTY;
                else ring_front = ring_front + 1'b1;
            end
            REQ_POP_REAR: begin
                if (is_empty) r.status = ST_EMPTY;
                else ring_rear = prev_rear;
            end
            REQ_PEEK_FRONT: begin
                if (is_empty) r.status = ST_EMPTY;
                else r.read_value = ring_mem[ring_front];
            end
            REQ_PEEK_REAR: begin
                if (is_empty) r.status = ST_EMPTY;
                else r.read_value = ring_mem[prev_rear];
            end
            default: begin
            end
        endcase
        r.fill_count = ring_rear - ring_front;
        return r;
    endfunction

    // Receiver side: random backpressure
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on each accepted request, compare each accepted result
    always @(posedge aclk) begin
        deque_result_t exp_r;
        deque_result_t act_r;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                act_r.read_value = m_axis_tdata[31:0];
                act_r.status     = m_axis_tdata[33:32];
                act_r.fill_count = m_axis_tdata[40:34];
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: value %h status %0d count %0d",
                                 act_r.read_value, act_r.status, act_r.fill_count);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (act_r != exp_r) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp %h %0d %0d act %h %0d %0d",
                                     exp_r.read_value, exp_r.status, exp_r.fill_count,
                                     act_r.read_value, act_r.status, act_r.fill_count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(deque_predict(s_axis_tdata[2:0], s_axis_tdata[34:3]));
        end
    end

    // Sends one request; starts and ends at a falling edge
    task automatic send_request(input logic [REQ_BITS-1:0] code, input logic [VALUE_BITS-1:0] value);
        if (requests_sent < 300) begin
            send_idle_pct = 27;
            recv_idle_pct = 66;
        end else if (requests_sent < 600) begin
            send_idle_pct = 66;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_BITS - 35){1'b0}}, value, code};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        requests_sent++;
    endtask

    function automatic logic [REQ_BITS-1:0] random_end(input logic [REQ_BITS-1:0] front_code,
                                                       input logic [REQ_BITS-1:0] rear_code);
        return ($urandom_range(0, 1) == 0) ? front_code : rear_code;
    endfunction

    // Empty-queue rejects, wraparound at both ends, extreme values, unused codes
    task automatic test_directed();
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_REAR,   32'hFFFF_FFFF);
        send_request(REQ_PEEK_FRONT, 32'h0000_0000);
        send_request(REQ_PEEK_REAR,  32'hFFFF_FFFF);
        send_request(REQ_UNUSED_6,   32'hFFFF_FFFF);
        send_request(REQ_UNUSED_7,   32'h0000_0000);
        // front steps back from slot 0, rear peek wraps to the top slot
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(REQ_PEEK_REAR,  32'h0000_0000);
        send_request(REQ_PUSH_REAR,  32'h7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(REQ_PUSH_REAR,  32'hFFFF_FFFF);
        send_request(REQ_PEEK_FRONT, 32'h1234_5678);
        send_request(REQ_PEEK_REAR,  32'h0000_0000);
        send_request(REQ_UNUSED_6,   32'h5555_AAAA);
        send_request(REQ_UNUSED_7,   32'hAAAA_5555);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_PEEK_FRONT, 32'h0000_0000);
        send_request(REQ_POP_REAR,   32'h0000_0000);
        send_request(REQ_PEEK_REAR,  32'h0000_0000);
        send_request(REQ_POP_REAR,   32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_PEEK_REAR,  32'h0000_0000);
    endtask

    // Fill to capacity from both ends, reject pushes when full, then drain
    task automatic test_full_and_drain();
        while (held_items() != IDX_BITS'(RING_DEPTH - 1))
            send_request(random_end(REQ_PUSH_FRONT, REQ_PUSH_REAR), $urandom());
        send_request(REQ_PUSH_FRONT, $urandom());
        send_request(REQ_PUSH_REAR,  $urandom());
        send_request(REQ_PEEK_FRONT, $urandom());
        send_request(REQ_PEEK_REAR,  $urandom());
        while (held_items() != 0) begin
            if ($urandom_range(0, 99) < 70)
                send_request(random_end(REQ_POP_FRONT, REQ_POP_REAR), $urandom());
            else
                send_request(random_end(REQ_PEEK_FRONT, REQ_PEEK_REAR), $urandom());
        end
        send_request(random_end(REQ_POP_FRONT, REQ_POP_REAR), $urandom());
    endtask

    // Random walk; push bias changes every block so the fill level swings widely
    task automatic test_random_mix();
        int push_pct;
        int roll;
        push_pct = 50;
        for (int n = 0; n < 620; n++) begin
            if (n % 80 == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    2:       push_pct = 85;
                    default: push_pct = 97;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_request(random_end(REQ_UNUSED_6, REQ_UNUSED_7), $urandom());
            else if (roll < 4 + (push_pct * 76) / 100)
                send_request(random_end(REQ_PUSH_FRONT, REQ_PUSH_REAR), $urandom());
            else if (roll < 80)
                send_request(random_end(REQ_POP_FRONT, REQ_POP_REAR), $urandom());
            else
                send_request(random_end(REQ_PEEK_FRONT, REQ_PEEK_REAR), $urandom());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_full_and_drain();
        test_random_mix();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
